### src/row_convex_fence_length_defines.svh
// Assertion macros shared by the row convex fence length block.
// Depends on signals clk and rst_n being visible where a macro is used.
`ifndef ROW_CONVEX_FENCE_LENGTH_DEFINES_SVH
`define ROW_CONVEX_FENCE_LENGTH_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RCFL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RCFL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/rcfl_pkg.sv
// Shared types and constants of the row convex fence length block.
// No dependencies.
package rcfl_pkg;

    localparam int ROW_BITS   = 64;   // width of one map row on the stream
    localparam int RW_W       = 7;    // row_width register width
    localparam int SCALE_W    = 10;   // scale_q4 register width
    localparam int CFG_DATA_W = 10;   // widest register
    localparam int CFG_IDX_W  = 1;
    localparam int OUT_W      = 30;   // fence_length_q4 width
    localparam int OUT_TDATA_W = 32;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_COUNT_BITS = 20;

    localparam logic [RW_W-1:0]    RW_RESET    = 7'd64;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 10'd40;
    localparam logic [OUT_W-1:0]   OUT_MAX     = {OUT_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 1'b1;

    // Control bits that travel with a row between stages.
    typedef struct packed {
        logic valid;
        logic last;
    } stage_ctl_t;

endpackage

### src/rcfl_edge.sv
// Edge stage: masks a row to the active width and finds its west and east edges.
// Depends on rcfl_pkg.
module rcfl_edge
    import rcfl_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int EW        = $clog2(MAX_WIDTH + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  stage_ctl_t           in_ctl,
    input  logic [MAX_WIDTH-1:0] row,
    input  logic [EW-1:0]        width,
    input  logic                 out_ready,
    output logic                 in_ready,
    output stage_ctl_t           out_ctl,
    output logic [EW-1:0]        west,
    output logic [EW-1:0]        east
);

    stage_ctl_t          ctl_reg, ctl_next;
    logic [EW-1:0]       west_reg, east_reg;
    logic [MAX_WIDTH-1:0] land;
    logic [EW-1:0]       lo, hi;
    logic                load;

    assign in_ready = !ctl_reg.valid || out_ready;
    assign load     = in_ctl.valid && in_ready;

    always_comb
    begin
        for (int j = 0; j < MAX_WIDTH; j++)
        begin
            land[j] = row[j] && (EW'(j) < width);
        end
    end

    // Lowest land column and one past the highest; the empty row is handled below.
    always_comb
    begin
        lo = '0;
        hi = '0;
        for (int j = MAX_WIDTH - 1; j >= 0; j--)
        begin
            if (land[j])
            begin
                lo = EW'(j);
            end
        end
        for (int j = 0; j < MAX_WIDTH; j++)
        begin
            if (land[j])
            begin
                hi = EW'(j + 1);
            end
        end
    end

    always_comb
    begin
        ctl_next = ctl_reg;
        if (load)
        begin
            ctl_next = in_ctl;
        end
        else if (out_ready)
        begin
            ctl_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            west_reg <= (|land) ? lo : width;
            east_reg <= (|land) ? hi : '0;
        end
    end

    assign out_ctl = ctl_reg;
    assign west    = west_reg;
    assign east    = east_reg;

endmodule

### src/rcfl_accum.sv
// Accumulator stage: adds each row's edge contribution and hands off the map total.
// Depends on rcfl_pkg.
module rcfl_accum
    import rcfl_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    parameter int EW         = $clog2(MAX_WIDTH + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  stage_ctl_t            in_ctl,
    input  logic [EW-1:0]         west,
    input  logic [EW-1:0]         east,
    input  logic                  out_ready,
    output logic                  in_ready,
    output logic                  total_valid,
    output logic [COUNT_BITS-1:0] total
);

    localparam int AW = EW + 2;
    localparam int SW = ((COUNT_BITS > AW) ? COUNT_BITS : AW) + 1;
    localparam logic [SW-1:0] CMAX = SW'({COUNT_BITS{1'b1}});

    logic [EW-1:0]         prev_west_reg, prev_west_next;
    logic [EW-1:0]         prev_east_reg, prev_east_next;
    logic                  first_reg, first_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  total_valid_reg, total_valid_next;
    logic [COUNT_BITS-1:0] total_reg;

    logic                  take;
    logic [EW-1:0]         land, dw, de;
    logic [AW-1:0]         add;
    logic [SW-1:0]         sum;
    logic [COUNT_BITS-1:0] sat;

    // Stall only a last row, and only while the previous total is still held.
    assign in_ready = !in_ctl.last || !total_valid_reg || out_ready;
    assign take     = in_ctl.valid && in_ready;

    always_comb
    begin
        land = (east > west) ? (east - west) : '0;
        dw   = (west > prev_west_reg) ? (west - prev_west_reg) : (prev_west_reg - west);
        de   = (east > prev_east_reg) ? (east - prev_east_reg) : (prev_east_reg - east);
        add  = '0;
        if (land != '0)
        begin
            add = AW'(2);
            if (!first_reg)
            begin
                add = add + AW'(dw) + AW'(de);
            end
        end
        if (first_reg)
        begin
            add = add + AW'(land);
        end
        if (in_ctl.last)
        begin
            add = add + AW'(land);
        end
        sum = SW'(count_reg) + SW'(add);
        sat = (sum > CMAX) ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
    end

    always_comb
    begin
        prev_west_next   = prev_west_reg;
        prev_east_next   = prev_east_reg;
        first_next       = first_reg;
        count_next       = count_reg;
        total_valid_next = total_valid_reg;
        if (out_ready)
        begin
            total_valid_next = 1'b0;
        end
        if (take)
        begin
            if (in_ctl.last)
            begin
                // Close the map and start the next one from reset values.
                prev_west_next   = '0;
                prev_east_next   = '0;
                first_next       = 1'b1;
                count_next       = '0;
                total_valid_next = 1'b1;
            end
            else
            begin
                prev_west_next = west;
                prev_east_next = east;
                first_next     = 1'b0;
                count_next     = sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_west_reg   <= '0;
            prev_east_reg   <= '0;
            first_reg       <= 1'b1;
            count_reg       <= '0;
            total_valid_reg <= 1'b0;
        end
        else
        begin
            prev_west_reg   <= prev_west_next;
            prev_east_reg   <= prev_east_next;
            first_reg       <= first_next;
            count_reg       <= count_next;
            total_valid_reg <= total_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && in_ctl.last)
        begin
            total_reg <= sat;
        end
    end

    assign total_valid = total_valid_reg;
    assign total       = total_reg;

endmodule

### src/rcfl_scale.sv
// Output stage: multiplies the map total by the cell scale and saturates.
// Depends on rcfl_pkg.
module rcfl_scale
    import rcfl_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [COUNT_BITS-1:0] total,
    input  logic [SCALE_W-1:0]    scale,
    input  logic                  out_ready,
    output logic                  in_ready,
    output logic                  out_valid,
    output logic [OUT_W-1:0]      fence
);

    localparam int PW = COUNT_BITS + SCALE_W;
    localparam int XW = PW + OUT_W;

    logic             valid_reg, valid_next;
    logic [OUT_W-1:0] fence_reg;
    logic [PW-1:0]    prod;
    logic [XW-1:0]    prod_ext;
    logic             load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;
    assign prod     = PW'(total) * PW'(scale);
    assign prod_ext = XW'(prod);

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            fence_reg <= (prod_ext > XW'(OUT_MAX)) ? OUT_MAX : prod_ext[OUT_W-1:0];
        end
    end

    assign out_valid = valid_reg;
    assign fence     = fence_reg;

endmodule

### src/row_convex_fence_length.sv
// Top level of the row convex fence length block: stream ports, register file, stages.
// Depends on rcfl_pkg, rcfl_edge, rcfl_accum, rcfl_scale and the defines header.
//
//  Channel   Direction  Transaction carries
//  s_*       in         one map row (tdata) and the last-row mark (tlast)
//  m_*       out        fence length of a finished map, q4 fixed point
//  cfg_*     in         register write: 0 row_width, 1 scale_q4
//
// One row is accepted every cycle unless a stall holds the flow; throughput is set by
// the edge encoders and the accumulate add, each with its own register stage. The
// result of a map passes the input, edge, total and output registers to m_tvalid.
// rst_n clears all valid bits, the map state and sets the registers to row_width 64
// and scale_q4 40. A stalled output holds only the last row of the next map; ordinary
// rows keep flowing.
`include "row_convex_fence_length_defines.svh"

module row_convex_fence_length
    import rcfl_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // s_tdata: row_bits[63:0]
    input  logic [ROW_BITS-1:0]    s_tdata,
    input  logic                   s_tlast,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // m_tdata: fence_length_q4[29:0], zero pad [31:30]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int EW = $clog2(MAX_WIDTH + 1);

    // Configuration registers.
    logic [RW_W-1:0]    row_width_reg, row_width_next;
    logic [SCALE_W-1:0] scale_reg, scale_next;
    logic [EW-1:0]      width_eff;

    // Input register.
    stage_ctl_t           in_ctl_reg, in_ctl_next;
    logic [MAX_WIDTH-1:0] row_reg;
    logic                 in_load;

    // Stage handshakes.
    logic                 edge_ready, acc_ready, scale_ready;
    stage_ctl_t           e_ctl;
    logic [EW-1:0]        e_west, e_east;
    logic                 acc_take;
    logic                 res_valid;
    logic [COUNT_BITS-1:0] res_total;
    logic [OUT_W-1:0]     fence;

    // Register writes; the index space is fully decoded.
    always_comb
    begin
        row_width_next = row_width_reg;
        scale_next     = scale_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROW_WIDTH: row_width_next = cfg_data[RW_W-1:0];
                CFG_SCALE:     scale_next     = cfg_data[SCALE_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= RW_RESET;
            scale_reg     <= SCALE_RESET;
        end
        else
        begin
            row_width_reg <= row_width_next;
            scale_reg     <= scale_next;
        end
    end

    // Clamp the programmed width to what the datapath holds.
    assign width_eff = (row_width_reg > RW_W'(MAX_WIDTH)) ? EW'(MAX_WIDTH)
                                                        : row_width_reg[EW-1:0];

    // Accept a row whenever the input register is empty or moving on.
    assign s_tready = !in_ctl_reg.valid || edge_ready;
    assign in_load  = s_tvalid && s_tready;

    always_comb
    begin
        in_ctl_next = in_ctl_reg;
        if (in_load)
        begin
            in_ctl_next.valid = 1'b1;
            in_ctl_next.last  = s_tlast;
        end
        else if (edge_ready)
        begin
            in_ctl_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ctl_reg <= '0;
        end
        else
        begin
            in_ctl_reg <= in_ctl_next;
        end
    end

    // Hold only the columns the datapath can use.
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            row_reg <= s_tdata[MAX_WIDTH-1:0];
        end
    end

    rcfl_edge #(
        .MAX_WIDTH (MAX_WIDTH),
        .EW        (EW)
    ) u_edge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctl    (in_ctl_reg),
        .row       (row_reg),
        .width     (width_eff),
        .out_ready (acc_ready),
        .in_ready  (edge_ready),
        .out_ctl   (e_ctl),
        .west      (e_west),
        .east      (e_east)
    );

    rcfl_accum #(
        .MAX_WIDTH  (MAX_WIDTH),
        .COUNT_BITS (COUNT_BITS),
        .EW         (EW)
    ) u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ctl      (e_ctl),
        .west        (e_west),
        .east        (e_east),
        .out_ready   (scale_ready),
        .in_ready    (acc_ready),
        .total_valid (res_valid),
        .total       (res_total)
    );

    rcfl_scale #(
        .COUNT_BITS (COUNT_BITS)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .total     (res_total),
        .scale     (scale_reg),
        .out_ready (m_tready),
        .in_ready  (scale_ready),
        .out_valid (m_tvalid),
        .fence     (fence)
    );

    assign acc_take = e_ctl.valid && acc_ready;
    assign m_tdata  = OUT_TDATA_W'(fence);

    // A full input register is the only reason to refuse a row.
    `RCFL_ASSERT_IMPL(a_ready_only_when_full, !s_tready, in_ctl_reg.valid,
        "input refused while input register empty")
    // A map total appears only right after a last row was absorbed.
    `RCFL_ASSERT_IMPL(a_total_from_last, $rose(res_valid), $past(acc_take && e_ctl.last),
        "map total raised without a last row")
    // A total that the output stage cannot take stays put.
    `RCFL_ASSERT_NEXT(a_total_held, res_valid && !scale_ready, res_valid,
        "map total dropped while output stage busy")

endmodule

### test/row_convex_fence_length_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the row convex fence length block: watches rows, register writes and results.
// Depends on rcfl_pkg for widths, register indexes and the output ceiling.
module row_convex_fence_length_checker
    import rcfl_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [ROW_BITS-1:0]    s_tdata,
    input  logic                   s_tlast,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     awaiting,
    output int                     rows_seen,
    output int                     maps_done
);

    localparam logic [63:0] COUNT_CEIL = (64'd1 << COUNT_BITS) - 64'd1;

    logic [RW_W-1:0]       row_width_q;
    logic [SCALE_W-1:0]    scale_q;
    logic [6:0]            prev_west;
    logic [6:0]            prev_east;
    logic                  at_first;
    logic [COUNT_BITS-1:0] edge_total;
    logic [OUT_W-1:0]      expected_len_q[$];
    logic [OUT_W-1:0]      want_len;

    function automatic int gap(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < 20)
            $display("checker: %s mismatch at %0t ns: got %0d, want %0d",
                     what, $time, got, want);
        fail_count++;
    endtask

    // Fold one row into the running edge count; queue the fence length on a last row.
    task automatic account_row(input logic [63:0] bits, input logic is_last);
        int               w;
        int               west;
        int               east;
        int               land;
        logic [63:0]      add;
        logic [63:0]      sum;
        logic [63:0]      len;
        logic [OUT_W-1:0] capped;
        w = (int'(row_width_q) > MAX_WIDTH) ? MAX_WIDTH : int'(row_width_q);
        west = w;
        east = 0;
        land = 0;
        for (int j = 0; j < w; j++)
        begin
            if (bits[j])
            begin
                if (west == w)
                    west = j;
                east = j + 1;
            end
        end
        if (east > west)
            land = east - west;
        add = 64'd0;
        if (land > 0)
        begin
            add += 64'd2;
            if (!at_first)
                add += 64'(gap(west, int'(prev_west)) + gap(east, int'(prev_east)));
        end
        if (at_first)
            add += 64'(land);
        if (is_last)
            add += 64'(land);
        sum = 64'(edge_total) + add;
        edge_total = (sum > COUNT_CEIL) ? COUNT_CEIL[COUNT_BITS-1:0] : sum[COUNT_BITS-1:0];
        prev_west = 7'(west);
        prev_east = 7'(east);
        at_first = 1'b0;
        if (is_last)
        begin
            len = 64'(edge_total) * 64'(scale_q);
            capped = (len > 64'(OUT_MAX)) ? OUT_MAX : len[OUT_W-1:0];
            expected_len_q.insert(expected_len_q.size(), capped);
            prev_west = '0;
            prev_east = '0;
            at_first = 1'b1;
            edge_total = '0;
            maps_done++;
        end
    endtask

    // Sample on the falling edge: inputs and outputs are steady until the next rising edge.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_q = RW_RESET;
            scale_q = SCALE_RESET;
            prev_west = '0;
            prev_east = '0;
            at_first = 1'b1;
            edge_total = '0;
            expected_len_q.delete();
            fail_count = 0;
            awaiting = 0;
            rows_seen = 0;
            maps_done = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_len_q.size() == 0)
                    report_mismatch("unexpected fence length", m_tdata, 32'd0);
                else
                begin
                    want_len = expected_len_q.pop_front();
                    if (m_tdata[OUT_W-1:0] !== want_len)
                        report_mismatch("fence_length_q4", 32'(m_tdata[OUT_W-1:0]),
                                        32'(want_len));
                    if (m_tdata[OUT_TDATA_W-1:OUT_W] !== '0)
                        report_mismatch("tdata pad", 32'(m_tdata[OUT_TDATA_W-1:OUT_W]),
                                        32'd0);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ROW_WIDTH: row_width_q = cfg_data[RW_W-1:0];
                    CFG_SCALE:     scale_q = cfg_data[SCALE_W-1:0];
                    default:       ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                account_row(s_tdata, s_tlast);
                rows_seen++;
            end
            awaiting = expected_len_q.size();
        end
    end

endmodule

### test/row_convex_fence_length_tb.sv
`timescale 1ns / 100ps
// Testbench top for the row convex fence length block: clock, reset, stimulus and verdict.
// Depends on rcfl_pkg, the block itself and row_convex_fence_length_checker.
module row_convex_fence_length_tb;
    import rcfl_pkg::*;

    // Generous bound: roughly 600 rows with idles, stalls and settle pauses fit
    // well inside it.
    localparam int CYCLE_LIMIT = 40000;
    localparam int RANDOM_ROWS = 540;
    localparam int ZIGZAG_ROWS = 40;
    // Quiet tail after the last result, padded for register writes.
    localparam int SETTLE_CYCLES = 8;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic [ROW_BITS-1:0]    s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int fail_count;
    int awaiting;
    int rows_seen;
    int maps_done;
    int cycle_count = 0;
    bit calm = 1'b0;     // set to suppress idles and stalls on both sides
    int cur_width = 64;  // row_width as last written, for shaping rows

    row_convex_fence_length dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    row_convex_fence_length_checker checker_i
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .awaiting   (awaiting),
        .rows_seen  (rows_seen),
        .maps_done  (maps_done)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Stall the result channel about a quarter of the time, never while calm.
    always @(posedge clk)
    begin
        m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 25);
    end

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic bit take_break();
        return !calm && ($urandom_range(0, 99) < 25);
    endfunction

    // Offer one row; return on the rising edge that accepts it, valid still high.
    // Called only on a rising-edge step, so each signal gets one assignment per step.
    task automatic send_row(input logic [63:0] bits, input logic is_last);
        bit ok;
        while (take_break())
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata <= bits;
        s_tlast <= is_last;
        s_tvalid <= 1'b1;
        do
        begin
            // tready is steady from the falling edge until the accepting edge.
            @(negedge clk);
            ok = s_tready;
            @(posedge clk);
        end
        while (!ok);
    endtask

    // Drop valid, wait for every queued fence length, then let the pipeline drain.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (awaiting != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write transaction, followed by a quiet cycle on the port.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx == CFG_ROW_WIDTH)
            cur_width = int'(value[RW_W-1:0]);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly contiguous land runs inside the width, with random, empty,
    // single-cell and holed rows mixed in; garbage beyond the width at times.
    function automatic logic [63:0] shape_row(input int w);
        int          ew;
        int          kind;
        int          lo;
        int          hi;
        logic [63:0] in_width;
        logic [63:0] run;
        ew = (w > 64) ? 64 : w;
        if (ew == 0)
            return rand64();
        in_width = ~({64{1'b1}} << ew);
        lo = $urandom_range(0, ew - 1);
        hi = $urandom_range(lo + 1, ew);
        run = ({64{1'b1}} << lo) & ~({64{1'b1}} << hi);
        kind = $urandom_range(0, 99);
        if (kind < 55)
        begin
            if ($urandom_range(0, 3) == 0)
                run |= rand64() & ~in_width;
            return run;
        end
        else if (kind < 70)
            return rand64();
        else if (kind < 80)
            return 64'd0;
        else if (kind < 90)
            return 64'd1 << $urandom_range(0, ew - 1);
        return run & rand64();
    endfunction

    // Pick new register values between maps, extremes and out-of-range widths included.
    task automatic reconfigure();
        int pick;
        int width;
        int scale;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       width = 0;
            1:       width = $urandom_range(65, 127);
            2:       width = 64;
            3:       width = 1;
            default: width = $urandom_range(1, 64);
        endcase
        pick = $urandom_range(0, 9);
        case (pick)
            0:       scale = 0;
            1:       scale = 1023;
            default: scale = $urandom_range(0, 1023);
        endcase
        settle();
        // Upper data bits are unused for row_width; drive them at random.
        write_reg(CFG_ROW_WIDTH, {3'($urandom), 7'(width)});
        write_reg(CFG_SCALE, 10'(scale));
    endtask

    initial
    begin
        int rows_sent;
        int map_idx;
        int len;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: default registers, full and empty single-row maps.
        send_row({64{1'b1}}, 1'b1);
        send_row(64'd0, 1'b1);
        // Map opening and closing on empty rows, edges at both extremes.
        send_row(64'd0, 1'b0);
        send_row(64'h0000_0000_0000_0001, 1'b0);
        send_row(64'h8000_0000_0000_0000, 1'b0);
        send_row(64'h8000_0000_0000_0001, 1'b0);
        send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_row(64'h5555_5555_5555_5555, 1'b0);
        send_row(64'd0, 1'b1);
        send_row(64'h0000_0FF0_0000_0000, 1'b0);
        send_row(64'h0000_00F0_0000_0000, 1'b1);

        // Zero width: every row is empty whatever its bits.
        settle();
        write_reg(CFG_SCALE, 10'd1023);
        write_reg(CFG_ROW_WIDTH, 10'd0);
        send_row(rand64(), 1'b0);
        send_row({64{1'b1}}, 1'b1);

        // Width above maximum, zero scale.
        settle();
        write_reg(CFG_ROW_WIDTH, 10'h3FF);
        write_reg(CFG_SCALE, 10'd0);
        send_row({64{1'b1}}, 1'b0);
        send_row(64'h8000_0000_0000_0000, 1'b1);

        // Width one: only bit 0 counts.
        settle();
        write_reg(CFG_ROW_WIDTH, 10'd1);
        write_reg(CFG_SCALE, 10'd1);
        send_row(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
        send_row(64'h0000_0000_0000_0001, 1'b0);
        send_row(64'h0000_0000_0000_0003, 1'b1);

        // Odd width with land beyond it; then width 65.
        settle();
        write_reg(CFG_ROW_WIDTH, 10'd37);
        send_row({64{1'b1}}, 1'b0);
        send_row(64'h0000_0010_0000_0000, 1'b0);
        send_row(64'h0000_0020_0000_0000, 1'b1);
        settle();
        write_reg(CFG_ROW_WIDTH, 10'd65);
        send_row(64'h8000_0000_0000_0000, 1'b1);

        // Widest edge swings: zig-zag single cells between the two outer columns.
        settle();
        write_reg(CFG_ROW_WIDTH, 10'd64);
        write_reg(CFG_SCALE, 10'd1023);
        for (int i = 0; i < ZIGZAG_ROWS; i++)
            send_row((i % 2) ? 64'h8000_0000_0000_0000 : 64'h1, i == ZIGZAG_ROWS - 1);

        // Random maps, mostly short, some long; registers change between some of them.
        rows_sent = 0;
        map_idx = 0;
        while (rows_sent < RANDOM_ROWS)
        begin
            if ($urandom_range(0, 3) == 0)
                reconfigure();
            // Hold a stretch of maps with no idles or stalls at all.
            calm = (map_idx >= 20 && map_idx < 30);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            for (int r = 0; r < len; r++)
            begin
                send_row(shape_row(cur_width), r == len - 1);
                rows_sent++;
            end
            map_idx++;
        end

        // Drain: every queued fence length must arrive, then a short tail.
        calm = 1'b0;
        s_tvalid <= 1'b0;
        while (awaiting != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("summary: %0d rows in %0d maps, one of them a %0d-row zig-zag",
                 rows_seen, maps_done, ZIGZAG_ROWS);
        $display("summary: row widths 0 to 127 and scales 0 to 1023, with random idles and stalls");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/rcfl_pkg.sv
src/rcfl_edge.sv
src/rcfl_accum.sv
src/rcfl_scale.sv
src/row_convex_fence_length.sv
test/row_convex_fence_length_checker.sv
test/row_convex_fence_length_tb.sv
